FILE: hw/rtl/sedb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sedb_pkg
// Shared constants, codes and control structs of the seam energy DP and
// backtrace core.
// ----------------------------------------------------------------------------
package sedb_pkg;

   // sizing
   localparam int MAX_LINE_LENGTH = 1024;
   localparam int MAX_LINE_COUNT  = 1024;
   localparam int ENERGY_BITS     = 8;

   localparam int POS_BITS  = $clog2(MAX_LINE_LENGTH);
   localparam int LINE_BITS = $clog2(MAX_LINE_COUNT);
   localparam int LEN_BITS  = $clog2(MAX_LINE_LENGTH + 1);
   localparam int CNT_BITS  = $clog2(MAX_LINE_COUNT + 1);

   // fixed field widths
   localparam int ENERGY_IN_BITS = 8;
   localparam int OUT_BITS       = 10;
   localparam int DIM_BITS       = 11;
   localparam int SUM_BITS       = 18;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 4;

   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
   localparam logic [ENERGY_IN_BITS-1:0] ENERGY_MASK =
      ENERGY_IN_BITS'((64'd1 << ENERGY_BITS) - 64'd1);

   // request kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_TRACE = 1'b1;

   // per-pixel step choices
   localparam logic [1:0] CH_CENTRE = 2'd0;
   localparam logic [1:0] CH_LEFT   = 2'd1;
   localparam logic [1:0] CH_RIGHT  = 2'd2;

   // register indexes
   typedef enum logic [1:0] {
      REG_SEAM_DIRECTION = 2'd0,
      REG_IMAGE_WIDTH    = 2'd1,
      REG_IMAGE_HEIGHT   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic                seam_direction;
      logic [DIM_BITS-1:0] image_width;
      logic [DIM_BITS-1:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic pix_start;
      logic pix_rd_right;
      logic pix_commit;
      logic trace_start;
      logic trace_step;
   } cmd_type;

   typedef struct packed {
      logic map_complete;
      logic trace_line_zero;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

FILE: hw/rtl/sedb_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sedb channels
// Valid/ready channel interfaces for requests and seam responses.
// ----------------------------------------------------------------------------
interface sedb_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [sedb_pkg::ENERGY_IN_BITS-1:0] energy;

   modport source (output valid, output kind, output energy, input ready);
   modport sink   (input valid, input kind, input energy, output ready);
endinterface

interface sedb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sedb_pkg::OUT_BITS-1:0] line_index;
   logic [sedb_pkg::OUT_BITS-1:0] seam_position;
   logic                          seam_last;

   modport source (output valid, output line_index, output seam_position,
                   output seam_last, input ready);
   modport sink   (input valid, input line_index, input seam_position,
                   input seam_last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sedb_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sedb_csr
// APB-style register file: seam direction and image size, with a restart
// pulse on every write to a known register.
// ----------------------------------------------------------------------------
module sedb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sedb_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [sedb_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [sedb_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output sedb_pkg::cfg_type                   cfg,
   output logic                                restart
);
   import sedb_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          wr_en;
   reg_index_type reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SEAM_DIRECTION: begin
               cfg_in.seam_direction = csr_pwdata[0];
               restart = 1'b1;
            end
            REG_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_pwdata[DIM_BITS-1:0];
               restart = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_pwdata[DIM_BITS-1:0];
               restart = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SEAM_DIRECTION: csr_prdata = CSR_DATA_BITS'(cfg_ff.seam_direction);
         REG_IMAGE_WIDTH:    csr_prdata = CSR_DATA_BITS'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:   csr_prdata = CSR_DATA_BITS'(cfg_ff.image_height);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seam_direction <= 1'b0;
         cfg_ff.image_width    <= DIM_BITS'(1024);
         cfg_ff.image_height   <= DIM_BITS'(1024);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/sedb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sedb_ctrl
// Sequencer: accepts requests and steps the datapath through pixel and
// trace operations.
// ----------------------------------------------------------------------------
module sedb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   input  sedb_pkg::status_type status,
   output sedb_pkg::cmd_type    cmd
);
   import sedb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_PIX_RD   = 4'b0010,
      ST_PIX_CALC = 4'b0100,
      ST_TRACE    = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      ready_w;

   assign req_ready = ready_w;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      ready_w  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // a trace request needs the output slot; a pixel does not
            ready_w = (req_kind == KIND_PIXEL) || status.out_free;
            if (req_valid && ready_w) begin
               if (req_kind == KIND_PIXEL) begin
                  cmd.pix_start = 1'b1;
                  state_in      = ST_PIX_RD;
               end else if (status.map_complete) begin
                  cmd.trace_start = 1'b1;
                  if (!status.trace_line_zero) begin
                     state_in = ST_TRACE;
                  end
               end
            end
         end
         ST_PIX_RD: begin
            cmd.pix_rd_right = 1'b1;
            state_in         = ST_PIX_CALC;
         end
         ST_PIX_CALC: begin
            cmd.pix_commit = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_TRACE: begin
            cmd.trace_step = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_pix_sequence: assert property (@(posedge clock) disable iff (reset)
      cmd.pix_start |=> state_ff == ST_PIX_RD ##1 state_ff == ST_PIX_CALC)
      else $error("pixel sequence broken");

   a_last_entry_no_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.trace_start && status.trace_line_zero) |=> state_ff == ST_IDLE)
      else $error("trace step after last seam entry");

endmodule
`default_nettype wire

FILE: hw/rtl/sedb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sedb_dp
// Datapath: ping-pong line-sum buffer, choice memory, map counters, best
// last-line tracking, trace walker and response register.
// ----------------------------------------------------------------------------
module sedb_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sedb_pkg::cfg_type                   cfg,
   input  logic                                restart,
   input  sedb_pkg::cmd_type                   cmd,
   output sedb_pkg::status_type                status,
   input  logic [sedb_pkg::ENERGY_IN_BITS-1:0] req_energy,
   sedb_rsp_if.source                          rsp_bus
);
   import sedb_pkg::*;

   localparam int SUM_DEPTH    = 2 * MAX_LINE_LENGTH;
   localparam int CHOICE_DEPTH = 2 ** (LINE_BITS + POS_BITS);

   function automatic logic [LEN_BITS-1:0] clamp_len(input logic [DIM_BITS-1:0] v);
      if (v == '0) return LEN_BITS'(1);
      if (32'(v) > MAX_LINE_LENGTH) return LEN_BITS'(MAX_LINE_LENGTH);
      return LEN_BITS'(v);
   endfunction

   function automatic logic [CNT_BITS-1:0] clamp_cnt(input logic [DIM_BITS-1:0] v);
      if (v == '0) return CNT_BITS'(1);
      if (32'(v) > MAX_LINE_COUNT) return CNT_BITS'(MAX_LINE_COUNT);
      return CNT_BITS'(v);
   endfunction

   function automatic logic [SUM_BITS-1:0] min2(input logic [SUM_BITS-1:0] a,
                                                input logic [SUM_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // memories
   logic [SUM_BITS-1:0] sum_mem    [0:SUM_DEPTH-1];
   logic [1:0]          choice_mem [0:CHOICE_DEPTH-1];

   // control state
   logic [POS_BITS-1:0]  pixel_in_line_ff;
   logic [LINE_BITS-1:0] line_counter_ff;
   logic [SUM_BITS-1:0]  best_last_sum_ff;
   logic [POS_BITS-1:0]  trace_pos_ff;
   logic [LINE_BITS-1:0] trace_line_ff;
   logic                 map_complete_ff;
   logic                 bank_ff;
   logic                 rsp_valid_ff;

   // payload
   logic [POS_BITS-1:0]       cur_p_ff;
   logic [LINE_BITS-1:0]      cur_l_ff;
   logic [ENERGY_IN_BITS-1:0] energy_ff;
   logic [SUM_BITS-1:0]       left_ff;
   logic [SUM_BITS-1:0]       rd_a_ff;
   logic [SUM_BITS-1:0]       rd_b_ff;
   logic [1:0]                choice_rd_ff;
   logic [OUT_BITS-1:0]       rsp_line_ff;
   logic [OUT_BITS-1:0]       rsp_pos_ff;
   logic                      rsp_last_ff;

   logic [LEN_BITS-1:0]  len;
   logic [CNT_BITS-1:0]  cnt;
   logic [LINE_BITS-1:0] last_line;
   logic [POS_BITS-1:0]  base_p, eff_p, left_idx, right_idx, pos_clamped, pos_step;
   logic [LINE_BITS-1:0] base_l, eff_l;
   logic [POS_BITS:0]    p_next, trace_next;
   logic [LINE_BITS:0]   l_next;
   logic                 rd_a_en;
   logic [POS_BITS:0]    rd_a_addr;
   logic [SUM_BITS-1:0]  min_lc, min_rc, min_all, sum;
   logic [SUM_BITS:0]    sum_wide;
   logic [1:0]           choice;

   assign len       = clamp_len(cfg.seam_direction ? cfg.image_height : cfg.image_width);
   assign cnt       = clamp_cnt(cfg.seam_direction ? cfg.image_width : cfg.image_height);
   assign last_line = LINE_BITS'(cnt - 1'b1);

   // effective position of the incoming pixel, after restart and wrap
   assign base_p = map_complete_ff ? '0 : pixel_in_line_ff;
   assign base_l = map_complete_ff ? '0 : line_counter_ff;
   assign eff_p  = ({1'b0, base_p} >= len) ? '0 : base_p;
   assign eff_l  = ({1'b0, base_l} >= cnt) ? '0 : base_l;

   assign left_idx  = (eff_p == '0) ? '0 : eff_p - 1'b1;
   assign p_next    = {1'b0, cur_p_ff} + 1'b1;
   assign l_next    = {1'b0, cur_l_ff} + 1'b1;
   assign right_idx = (p_next < len) ? p_next[POS_BITS-1:0] : POS_BITS'(len - 1'b1);

   // port A reads the left neighbor first, then the right one
   assign rd_a_en   = cmd.pix_start || cmd.pix_rd_right;
   assign rd_a_addr = cmd.pix_start ? {~bank_ff, left_idx} : {~bank_ff, right_idx};

   always_ff @(posedge clock) begin
      if (cmd.pix_commit) begin
         sum_mem[{bank_ff, cur_p_ff}] <= sum;
      end
      if (rd_a_en) begin
         rd_a_ff <= sum_mem[rd_a_addr];
      end
      if (cmd.pix_start) begin
         rd_b_ff <= sum_mem[{~bank_ff, eff_p}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_commit) begin
         choice_mem[{cur_l_ff, cur_p_ff}] <= choice;
      end
      if (cmd.trace_start) begin
         choice_rd_ff <= choice_mem[{trace_line_ff, pos_clamped}];
      end
   end

   // neighbors: left_ff, center rd_b_ff, right rd_a_ff
   assign min_lc  = min2(left_ff, rd_b_ff);
   assign min_rc  = min2(rd_a_ff, rd_b_ff);
   assign min_all = min2(min_lc, rd_a_ff);

   always_comb begin
      if (cur_l_ff == '0) begin
         sum_wide = (SUM_BITS+1)'(energy_ff);
         choice   = CH_CENTRE;
      end else begin
         sum_wide = {1'b0, min_all} + (SUM_BITS+1)'(energy_ff);
         if (min_lc > rd_a_ff) begin
            choice = CH_RIGHT;
         end else if (min_rc > left_ff) begin
            choice = CH_LEFT;
         end else begin
            choice = CH_CENTRE;
         end
      end
      sum = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
   end

   // trace walker
   assign pos_clamped = ({1'b0, trace_pos_ff} >= len) ? POS_BITS'(len - 1'b1)
                                                      : trace_pos_ff;
   assign trace_next  = {1'b0, trace_pos_ff} + 1'b1;

   always_comb begin
      pos_step = trace_pos_ff;
      if (choice_rd_ff == CH_RIGHT && trace_next < len) begin
         pos_step = trace_next[POS_BITS-1:0];
      end else if (choice_rd_ff == CH_LEFT && trace_pos_ff != '0) begin
         pos_step = trace_pos_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_in_line_ff <= '0;
         line_counter_ff  <= '0;
         best_last_sum_ff <= SUM_MAX;
         trace_pos_ff     <= '0;
         trace_line_ff    <= '0;
         map_complete_ff  <= 1'b0;
         bank_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (restart) begin
            pixel_in_line_ff <= '0;
            line_counter_ff  <= '0;
            best_last_sum_ff <= SUM_MAX;
            trace_pos_ff     <= '0;
            trace_line_ff    <= '0;
            map_complete_ff  <= 1'b0;
         end else begin
            if (cmd.pix_start) begin
               map_complete_ff <= 1'b0;
               if (map_complete_ff) begin
                  trace_pos_ff  <= '0;
                  trace_line_ff <= '0;
               end
               if (map_complete_ff || (eff_l == '0 && eff_p == '0)) begin
                  best_last_sum_ff <= SUM_MAX;
               end
            end
            if (cmd.pix_commit) begin
               if (cur_l_ff == last_line && sum < best_last_sum_ff) begin
                  best_last_sum_ff <= sum;
                  trace_pos_ff     <= cur_p_ff;
               end
               if (p_next < len) begin
                  pixel_in_line_ff <= p_next[POS_BITS-1:0];
                  line_counter_ff  <= cur_l_ff;
               end else begin
                  pixel_in_line_ff <= '0;
                  bank_ff          <= ~bank_ff;
                  if (l_next < cnt) begin
                     line_counter_ff <= l_next[LINE_BITS-1:0];
                  end else begin
                     line_counter_ff <= '0;
                     trace_line_ff   <= last_line;
                     map_complete_ff <= 1'b1;
                  end
               end
            end
            if (cmd.trace_start) begin
               rsp_valid_ff <= 1'b1;
               if (trace_line_ff == '0) begin
                  map_complete_ff <= 1'b0;
               end else begin
                  trace_pos_ff <= pos_clamped;
               end
            end
            if (cmd.trace_step) begin
               trace_pos_ff  <= pos_step;
               trace_line_ff <= trace_line_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_start) begin
         cur_p_ff  <= eff_p;
         cur_l_ff  <= eff_l;
         energy_ff <= req_energy & ENERGY_MASK;
      end
      if (cmd.pix_rd_right) begin
         left_ff <= rd_a_ff;
      end
      if (cmd.trace_start) begin
         rsp_line_ff <= OUT_BITS'(trace_line_ff);
         rsp_pos_ff  <= OUT_BITS'(trace_pos_ff);
         rsp_last_ff <= (trace_line_ff == '0);
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.line_index    = rsp_line_ff;
   assign rsp_bus.seam_position = rsp_pos_ff;
   assign rsp_bus.seam_last     = rsp_last_ff;

   assign status.map_complete    = map_complete_ff;
   assign status.trace_line_zero = (trace_line_ff == '0);
   assign status.out_free        = !rsp_valid_ff || rsp_bus.ready;

   a_complete_counters_home: assert property (@(posedge clock) disable iff (reset)
      map_complete_ff |-> (pixel_in_line_ff == '0 && line_counter_ff == '0))
      else $error("map complete with counters away from origin");

   a_step_not_past_line0: assert property (@(posedge clock) disable iff (reset)
      cmd.trace_step |-> (trace_line_ff != '0 || $past(restart)))
      else $error("trace step below line zero");

   a_rsp_from_trace: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.trace_start))
      else $error("response without trace request");

endmodule
`default_nettype wire

FILE: hw/rtl/seam_energy_dp_backtrace_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seam_energy_dp_backtrace_core
// Cumulative seam energy map with stored step choices and seam backtrace.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake             payload
//   req_bus   in          valid/ready           kind, energy
//   rsp_bus   out         valid/ready           line_index, seam_position,
//                                               seam_last
//   csr_*     in/out      APB setup + access    seam_direction, image_width,
//                                               image_height
//
// An energy pixel steps through the accept state, then ST_PIX_RD and ST_PIX_CALC:
// port A of the line-sum buffer fetches the left and then the right neighbor
// ahead of the registered add/compare and write-back.
// A trace request uses the accept state and then ST_TRACE, skipped for the
// line-0 entry or with no map, since the choice memory read is registered.
// Reset clears the counters and flags; the sum and choice memories are not
// cleared, every entry is written before it is read.
// A response holds in its output register until taken; pixels are still
// accepted meanwhile, a trace request waits until the output slot frees.
//
module seam_energy_dp_backtrace_core (
   input  logic                                clock,
   input  logic                                reset,
   sedb_req_if.sink                            req_bus,
   sedb_rsp_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sedb_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [sedb_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [sedb_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import sedb_pkg::*;

   cfg_type    cfg;
   logic       restart;
   cmd_type    cmd;
   status_type status;

   // configuration registers; any known write restarts the map
   sedb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .restart     (restart)
   );

   // sequencer: owns the request handshake
   sedb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: memories, counters, trace walker and response register
   sedb_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .restart    (restart),
      .cmd        (cmd),
      .status     (status),
      .req_energy (req_bus.energy),
      .rsp_bus    (rsp_bus)
   );

endmodule
`default_nettype wire

FILE: tb/seam_energy_dp_backtrace_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seam_energy_dp_backtrace_core_test
// Self-checking bench for the seam energy DP and backtrace core. A queue-fed
// driver streams pixel and trace requests, a request-level predictor tracks the
// cumulative sums, step choices and seam walk, and a monitor checks every seam
// entry in order. Geometry is changed through the APB port with readback.
// ----------------------------------------------------------------------------
module seam_energy_dp_backtrace_core_test;
   import sedb_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int IDLE_PERCENT  = 21;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 300;
   localparam int REPORT_LIMIT  = 10;

   // address with no register behind it; a write there must leave the map alone
   localparam logic [CSR_ADDR_BITS-1:0] UNMAPPED_ADDR = 4'd12;

   typedef struct packed {
      logic                      kind;
      logic [ENERGY_IN_BITS-1:0] energy;
   } seam_request_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] line_index;
      logic [OUT_BITS-1:0] seam_position;
      logic                seam_last;
   } seam_entry_type;

   // ------------------------------------------------------------------------
   // clock, reset and block inputs; every input starts at a known value
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   logic                      req_valid  = 1'b0;
   logic                      req_kind   = KIND_PIXEL;
   logic [ENERGY_IN_BITS-1:0] req_energy = '0;
   logic                      rsp_ready  = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   sedb_req_if req_ch ();
   sedb_rsp_if rsp_ch ();

   assign req_ch.valid  = req_valid;
   assign req_ch.kind   = req_kind;
   assign req_ch.energy = req_energy;
   assign rsp_ch.ready  = rsp_ready;

   seam_energy_dp_backtrace_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------------
   // shared bench state
   // ------------------------------------------------------------------------
   seam_request_type pending_requests [$];   // requests not yet accepted
   seam_entry_type   seam_entries_due [$];   // seam entries still to arrive
   int               mismatch_count = 0;
   bit               idle_jitter    = 1'b1;  // random idling on both sides
   int               stall_gen      = 0;     // bump to start a long receiver hold

   // ------------------------------------------------------------------------
   // predictor: geometry mirror and map state
   // ------------------------------------------------------------------------
   logic                cfg_direction = 1'b0;
   logic [DIM_BITS-1:0] cfg_width     = DIM_BITS'(1024);
   logic [DIM_BITS-1:0] cfg_height    = DIM_BITS'(1024);

   logic [SUM_BITS-1:0] upper_sums  [MAX_LINE_LENGTH];   // sums of the line above
   logic [SUM_BITS-1:0] line_sums   [MAX_LINE_LENGTH];   // sums of the line in work
   bit   [1:0]          step_memory [MAX_LINE_LENGTH*MAX_LINE_COUNT];

   int unsigned         next_pixel     = 0;
   int unsigned         next_line      = 0;
   int unsigned         walk_position  = 0;
   int unsigned         walk_line      = 0;
   logic [SUM_BITS-1:0] least_last_sum = SUM_MAX;
   logic                map_ready      = 1'b0;

   function automatic void report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("MISMATCH %s", what);
   endfunction

   function automatic int unsigned clamp_extent(logic [DIM_BITS-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // positions per line: width for a vertical seam, height for a horizontal one
   function automatic int unsigned map_length();
      return clamp_extent(cfg_direction ? cfg_height : cfg_width, MAX_LINE_LENGTH);
   endfunction

   function automatic int unsigned map_lines();
      return clamp_extent(cfg_direction ? cfg_width : cfg_height, MAX_LINE_COUNT);
   endfunction

   function automatic int unsigned lesser(int unsigned a, int unsigned b);
      return a < b ? a : b;
   endfunction

   function automatic void restart_seam_map();
      next_pixel     = 0;
      next_line      = 0;
      least_last_sum = SUM_MAX;
      walk_position  = 0;
      walk_line      = 0;
      map_ready      = 1'b0;
   endfunction

   // any write to a real register drops the map in progress
   function automatic void apply_register(logic [CSR_ADDR_BITS-1:0] addr,
                                          logic [CSR_DATA_BITS-1:0] value);
      case (addr >> 2)
         REG_SEAM_DIRECTION: cfg_direction = value[0];
         REG_IMAGE_WIDTH:    cfg_width     = value[DIM_BITS-1:0];
         REG_IMAGE_HEIGHT:   cfg_height    = value[DIM_BITS-1:0];
         default:            return;
      endcase
      restart_seam_map();
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] register_value(logic [CSR_ADDR_BITS-1:0] addr);
      case (addr >> 2)
         REG_SEAM_DIRECTION: return CSR_DATA_BITS'(cfg_direction);
         REG_IMAGE_WIDTH:    return CSR_DATA_BITS'(cfg_width);
         default:            return CSR_DATA_BITS'(cfg_height);
      endcase
   endfunction

   // Advance the map by one accepted request and queue the seam entry it yields.
   function automatic void predict_seam_request(seam_request_type r);
      int unsigned    len, cnt, p, l, sum, lf, ct, rt;
      logic [1:0]     choice;
      seam_entry_type entry;
      len = map_length();
      cnt = map_lines();
      if (r.kind == KIND_PIXEL) begin
         // a pixel after a finished map starts a new one and drops the trace
         if (map_ready) restart_seam_map();
         if (next_pixel >= len) next_pixel = 0;
         if (next_line >= cnt) next_line = 0;
         if (next_line == 0 && next_pixel == 0) least_last_sum = SUM_MAX;
         p      = next_pixel;
         l      = next_line;
         choice = CH_CENTRE;
         if (l == 0) begin
            sum = r.energy & ENERGY_MASK;
         end else begin
            // neighbors clamp at both ends of the line
            ct = upper_sums[p];
            lf = upper_sums[p > 0 ? p - 1 : 0];
            rt = upper_sums[p + 1 < len ? p + 1 : len - 1];
            // centre wins every tie, also a left/right tie below it
            if (lesser(lf, ct) > rt)      choice = CH_RIGHT;
            else if (lesser(rt, ct) > lf) choice = CH_LEFT;
            sum = (r.energy & ENERGY_MASK) + lesser(ct, lesser(lf, rt));
         end
         if (sum > SUM_MAX) sum = SUM_MAX;
         line_sums[p] = SUM_BITS'(sum);
         step_memory[l * MAX_LINE_LENGTH + p] = choice;
         // strict compare keeps the first minimum of the last line
         if (l == cnt - 1 && sum < least_last_sum) begin
            least_last_sum = SUM_BITS'(sum);
            walk_position  = p;
         end
         if (p + 1 < len) begin
            next_pixel = p + 1;
         end else begin
            next_pixel = 0;
            for (int i = 0; i < len; i++) upper_sums[i] = line_sums[i];
            if (l + 1 < cnt) begin
               next_line = l + 1;
            end else begin
               next_line = 0;
               walk_line = cnt - 1;
               map_ready = 1'b1;
            end
         end
      end else if (map_ready) begin
         entry.line_index    = OUT_BITS'(walk_line);
         entry.seam_position = OUT_BITS'(walk_position);
         entry.seam_last     = (walk_line == 0);
         seam_entries_due.push_back(entry);
         if (walk_line == 0) begin
            map_ready = 1'b0;       // seam finished, further traces are ignored
         end else begin
            if (walk_position >= len) walk_position = len - 1;
            choice = step_memory[walk_line * MAX_LINE_LENGTH + walk_position];
            if (choice == CH_RIGHT && walk_position + 1 < len) walk_position++;
            else if (choice == CH_LEFT && walk_position > 0)   walk_position--;
            walk_line--;
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // driver: offer the oldest pending request, predict it once accepted
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ch.ready) begin
            predict_seam_request('{req_kind, req_energy});
            pending_requests.delete(0);
         end
         // hold an offered request until it is taken, else roll for idling
         offer = req_valid && !req_ch.ready;
         if (!offer)
            offer = pending_requests.size() != 0 &&
                    !(idle_jitter && $urandom_range(99) < IDLE_PERCENT);
         req_valid <= offer;
         if (offer) begin
            req_kind   <= pending_requests[0].kind;
            req_energy <= pending_requests[0].energy;
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: check each seam entry against the oldest prediction
   // ------------------------------------------------------------------------
   int hold_left  = 0;
   int stall_seen = 0;

   always @(posedge clock) begin
      seam_entry_type seen, due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ready) begin
            seen = '{rsp_ch.line_index, rsp_ch.seam_position, rsp_ch.seam_last};
            if (seam_entries_due.size() == 0) begin
               report_mismatch($sformatf("unexpected seam entry line %0d pos %0d last %0b",
                                         seen.line_index, seen.seam_position,
                                         seen.seam_last));
            end else begin
               due = seam_entries_due.pop_front();
               if (seen !== due)
                  report_mismatch($sformatf(
                     "seam entry: expected line %0d pos %0d last %0b, got line %0d pos %0d last %0b",
                     due.line_index, due.seam_position, due.seam_last,
                     seen.line_index, seen.seam_position, seen.seam_last));
            end
         end
         // long hold-off: count it down here so the sender keeps pushing
         if (stall_gen != stall_seen) begin
            stall_seen = stall_gen;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idle_jitter && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void queue_pixel(logic [ENERGY_IN_BITS-1:0] e);
      pending_requests.push_back('{KIND_PIXEL, e});
   endfunction

   function automatic void queue_trace(int n);
      repeat (n) pending_requests.push_back('{KIND_TRACE, ENERGY_IN_BITS'($urandom_range(255))});
   endfunction

   // flavor 0: full range, 1: tiny values full of ties, 2: only the extremes
   function automatic logic [ENERGY_IN_BITS-1:0] pick_energy(int flavor);
      case (flavor)
         0:       return ENERGY_IN_BITS'($urandom_range(255));
         1:       return ENERGY_IN_BITS'($urandom_range(3));
         default: return $urandom_range(1) ? '1 : '0;
      endcase
   endfunction

   function automatic void queue_map(int unsigned len, int unsigned cnt, int flavor);
      repeat (len * cnt) queue_pixel(pick_energy(flavor));
   endfunction

   // Wait until every request is taken and every entry is back, then let a
   // pixel still in the pipe settle before the port is touched.
   task automatic drain();
      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (seam_entries_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write (setup, access), then read a mapped register back
   task automatic write_register(logic [CSR_ADDR_BITS-1:0] addr,
                                 logic [CSR_DATA_BITS-1:0] value);
      logic readable;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_register(addr, value);
      readable = (addr >> 2) <= REG_IMAGE_HEIGHT;
      csr_psel    <= readable;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (readable) begin
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (csr_prdata !== register_value(addr))
            report_mismatch($sformatf("register at 0x%0h: expected 0x%0h, got 0x%0h",
                                      addr, register_value(addr), csr_prdata));
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   task automatic set_geometry(logic dir, int unsigned w, int unsigned h);
      write_register({REG_SEAM_DIRECTION, 2'b00}, CSR_DATA_BITS'(dir));
      write_register({REG_IMAGE_WIDTH, 2'b00}, CSR_DATA_BITS'(w));
      write_register({REG_IMAGE_HEIGHT, 2'b00}, CSR_DATA_BITS'(h));
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [ENERGY_IN_BITS-1:0] corner_energy [9];
      logic                      dir;
      logic [DIM_BITS-1:0]       w, h;
      logic [CSR_DATA_BITS-1:0]  junk;
      int unsigned               len, cnt, span, depth;
      int                        items, flavor;

      corner_energy = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h09, 8'h09, 8'h09};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // trace with no map is ignored; the partial map is dropped by the writes
      queue_trace(1);
      queue_pixel('1);
      queue_pixel('0);
      queue_trace(1);
      drain();

      // small vertical map with left, right and centre steps, plus one extra trace
      set_geometry(1'b0, 3, 3);
      foreach (corner_energy[i]) queue_pixel(corner_energy[i]);
      queue_trace(4);
      drain();

      // flat map, all ties; an unmapped write mid-map must not restart it
      repeat (4) queue_pixel(8'd40);
      drain();
      write_register(UNMAPPED_ADDR, '1);
      repeat (5) queue_pixel(8'd40);
      queue_trace(3);
      drain();

      // trace cut short by a pixel: the new map replaces the old seam
      queue_map(3, 3, 0);
      queue_trace(1);
      queue_map(3, 3, 0);
      queue_trace(3);
      drain();

      // zero sizes clamp to a single pixel
      set_geometry(1'b0, 0, 0);
      queue_pixel(8'h5A);
      queue_trace(2);
      drain();

      // horizontal seam: lines are columns
      set_geometry(1'b1, 2, 3);
      queue_map(3, 2, 0);
      queue_trace(3);
      drain();

      // widest line, minimum at the last position; run without idling
      idle_jitter = 1'b0;
      set_geometry(1'b0, 2047, 1);
      repeat (MAX_LINE_LENGTH - 1) queue_pixel('1);
      queue_pixel('0);
      queue_trace(2);
      drain();
      idle_jitter = 1'b1;

      // deep map, one position per line: line index walks down from the top
      set_geometry(1'b1, 150, 1);
      queue_map(1, 150, 0);
      queue_trace(151);
      drain();

      // hold the receiver while traces pile up, then restart with pixels
      set_geometry(1'b0, 4, 12);
      queue_map(4, 12, 0);
      drain();
      stall_gen <= stall_gen + 1;
      queue_trace(10);
      queue_map(4, 12, 1);
      queue_trace(13);
      drain();

      // random geometries, mostly complete maps and full traces
      items = 0;
      while (items < RANDOM_ITEMS) begin
         dir = 1'($urandom_range(1));
         case ($urandom_range(19))
            0: begin
               span  = $urandom_range(13, 300);
               depth = $urandom_range(0, 2);
            end
            1: begin
               span  = $urandom_range(0, 2);
               depth = $urandom_range(13, 120);
            end
            default: begin
               span  = $urandom_range(0, 12);
               depth = $urandom_range(0, 12);
            end
         endcase
         w    = DIM_BITS'(dir ? depth : span);
         h    = DIM_BITS'(dir ? span : depth);
         junk = $urandom_range(3) == 0 ? $urandom() : '0;
         // write what changed, and sometimes rewrite an unchanged register
         if (dir != cfg_direction || $urandom_range(3) == 0)
            write_register({REG_SEAM_DIRECTION, 2'b00}, (junk << 1) | CSR_DATA_BITS'(dir));
         if (w != cfg_width || $urandom_range(3) == 0)
            write_register({REG_IMAGE_WIDTH, 2'b00}, (junk << DIM_BITS) | CSR_DATA_BITS'(w));
         if (h != cfg_height || $urandom_range(3) == 0)
            write_register({REG_IMAGE_HEIGHT, 2'b00}, (junk << DIM_BITS) | CSR_DATA_BITS'(h));
         len = map_length();
         cnt = map_lines();

         repeat ($urandom_range(1, 2)) begin
            flavor = $urandom_range(2);
            case ($urandom_range(9))
               0: begin
                  // seam abandoned partway; the next pixel starts over
                  queue_map(len, cnt, flavor);
                  queue_trace($urandom_range(0, cnt - 1));
                  items += len * cnt;
               end
               1: begin
                  // noise: loose mix of pixels and traces
                  repeat ($urandom_range(1, 20)) begin
                     if ($urandom_range(1)) queue_trace(1);
                     else queue_pixel(pick_energy(flavor));
                  end
               end
               default: begin
                  queue_map(len, cnt, flavor);
                  queue_trace(cnt + $urandom_range(0, 2));
                  items += len * cnt + cnt;
               end
            endcase
         end
         drain();
      end

      if (mismatch_count == 0 && seam_entries_due.size() == 0)
         $display("seam_energy_dp_backtrace_core verification clean");
      else
         $display("seam_energy_dp_backtrace_core verification failed");
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #6ms;
      $display("seam_energy_dp_backtrace_core verification failed");
      $finish;
   end

endmodule
